FILE: hw/rtl/irr_pkg.sv
// ----------------------------------------------------------------------------
// Image rotate resampler package
// Shared types and register indexes.
// ----------------------------------------------------------------------------
package irr_pkg;

   localparam int unsigned CfgIdxWidth = 3;
   localparam logic [31:0] WhitePixel = 32'hFFFF_FFFF;

   typedef enum logic [CfgIdxWidth-1:0] {
      REG_MODE       = 3'd0,
      REG_COS        = 3'd1,
      REG_SIN        = 3'd2,
      REG_OFFSET_X   = 3'd3,
      REG_OFFSET_Y   = 3'd4,
      REG_SRC_WIDTH  = 3'd5,
      REG_SRC_HEIGHT = 3'd6
   } reg_index_type;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_PRODUCE = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [8:0]  coord_x;
      logic [8:0]  coord_y;
      logic [31:0] pixel_in;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] pixel_out;
      logic        outside;
   } rsp_beat_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] data;
   } csr_beat_type;

endpackage

FILE: hw/rtl/irr_if.sv
// ----------------------------------------------------------------------------
// Image rotate resampler channels
// Valid/ready channel interfaces carrying one beat each.
// ----------------------------------------------------------------------------
interface irr_req_if;
   import irr_pkg::*;
   logic         valid;
   logic         ready;
   req_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface irr_rsp_if;
   import irr_pkg::*;
   logic         valid;
   logic         ready;
   rsp_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface irr_csr_if;
   import irr_pkg::*;
   logic         valid;
   logic         ready;
   csr_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/image_rotate_resampler.sv
// ----------------------------------------------------------------------------
// Image rotate resampler
// Rotates output coordinates into a stored ARGB source frame and samples it
// by nearest neighbour or bilinear blend.
//
//   channel  role     carries
//   req      sink     kind, coord_x, coord_y, pixel_in
//   rsp      source   pixel_out, outside (one beat per produce beat)
//   csr      sink     register index, write data
//
// One beat per cycle sustained while rsp is ready. The four neighbours come
// from four parity banks read at once.
// A two-entry queue parts the rotate front end from the sampling back end.
// Reset clears control state only; the frame store holds no valid bits.
// ----------------------------------------------------------------------------
module image_rotate_resampler #(
   parameter int unsigned MAX_WIDTH = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned FRAC_BITS = 14
) (
   input logic      clock,
   input logic      reset,
   irr_req_if.sink  req,
   irr_rsp_if.source rsp,
   irr_csr_if.sink  csr
);
   import irr_pkg::*;

   localparam int unsigned XW = $clog2(MAX_WIDTH);
   localparam int unsigned YW = $clog2(MAX_HEIGHT);
   localparam int unsigned QW = 2 + XW + YW + 2 * FRAC_BITS + 32;

   logic               mode_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic signed [10:0] offx_ff, offy_ff;
   logic [8:0]         w_ff, h_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cos_ff  <= 16'sd16384;
         sin_ff  <= '0;
         offx_ff <= '0;
         offy_ff <= '0;
         w_ff    <= 9'd256;
         h_ff    <= 9'd256;
      end else if (csr.valid) begin
         case (reg_index_type'(csr.data.index))
            REG_MODE:       mode_ff <= csr.data.data[0];
            REG_COS:        cos_ff  <= csr.data.data[15:0];
            REG_SIN:        sin_ff  <= csr.data.data[15:0];
            REG_OFFSET_X:   offx_ff <= csr.data.data[10:0];
            REG_OFFSET_Y:   offy_ff <= csr.data.data[10:0];
            REG_SRC_WIDTH:  w_ff    <= csr.data.data[8:0];
            REG_SRC_HEIGHT: h_ff    <= csr.data.data[8:0];
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready, f_kind, f_out;
   logic [XW-1:0] f_x;
   logic [YW-1:0] f_y;
   logic [FRAC_BITS-1:0] f_uf, f_vf;
   logic [31:0] f_pix;

   // Out-of-range loads are flagged by the outside bit on their way in.
   irr_front #(.XW(XW), .YW(YW), .FRAC_BITS(FRAC_BITS),
               .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .cos_q(cos_ff), .sin_q(sin_ff), .offset_x(offx_ff), .offset_y(offy_ff),
      .src_width(w_ff), .src_height(h_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_kind(f_kind),
      .out_outside(f_out), .out_x(f_x), .out_y(f_y),
      .out_uf(f_uf), .out_vf(f_vf), .out_pixel(f_pix)
   );

   logic [QW-1:0] q_ff [2];
   logic [1:0]    q_cnt_ff, q_cnt_in;
   logic          q_rd_ff, q_rd_in, q_wr_ff, q_wr_in;
   logic          q_push, q_pop, b_ready;
   logic [QW-1:0] q_head;

   assign f_ready = q_cnt_ff != 2'd2;
   assign q_push  = f_valid && f_ready;
   assign q_pop   = q_cnt_ff != 2'd0 && b_ready;
   assign q_cnt_in = q_cnt_ff + 2'(q_push) - 2'(q_pop);
   assign q_rd_in = q_rd_ff ^ q_pop;
   assign q_wr_in = q_wr_ff ^ q_push;
   assign q_head  = q_ff[q_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_rd_ff  <= 1'b0;
         q_wr_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         q_rd_ff  <= q_rd_in;
         q_wr_ff  <= q_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= {f_kind, f_out, f_x, f_y, f_uf, f_vf, f_pix};
      end
   end

   logic h_kind, h_out;
   logic [XW-1:0] h_x;
   logic [YW-1:0] h_y;
   logic [FRAC_BITS-1:0] h_uf, h_vf;
   logic [31:0] h_pix;
   assign {h_kind, h_out, h_x, h_y, h_uf, h_vf, h_pix} = q_head;

   // A load flagged outside lies beyond the store and writes nothing.
   irr_back #(.XW(XW), .YW(YW), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .mode(mode_ff),
      .in_valid(q_cnt_ff != 2'd0), .in_ready(b_ready),
      .in_kind(h_kind), .in_outside(h_out), .in_load_ok(!h_out),
      .in_x(h_x), .in_y(h_y), .in_uf(h_uf), .in_vf(h_vf), .in_pixel(h_pix),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff == 2'd2 |-> !f_ready) else $error("queue overflow");
   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.outside |-> rsp.data.pixel_out == WhitePixel)
      else $error("outside result not white");
`endif
endmodule

FILE: hw/rtl/irr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module irr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/irr_front.sv
// ----------------------------------------------------------------------------
// Image rotate resampler front end
// Accepts beats, rotates produce coordinates in three stages and classifies
// them as load, outside or inside before they enter the queue.
// ----------------------------------------------------------------------------
module irr_front #(
   parameter int unsigned XW = 8,
   parameter int unsigned YW = 8,
   parameter int unsigned FRAC_BITS = 14,
   parameter int unsigned MAX_WIDTH = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  irr_pkg::req_beat_type         in_data,
   input  logic signed [15:0]            cos_q,
   input  logic signed [15:0]            sin_q,
   input  logic signed [10:0]            offset_x,
   input  logic signed [10:0]            offset_y,
   input  logic [8:0]                    src_width,
   input  logic [8:0]                    src_height,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_kind,
   output logic                          out_outside,
   output logic [XW-1:0]                 out_x,
   output logic [YW-1:0]                 out_y,
   output logic [FRAC_BITS-1:0]          out_uf,
   output logic [FRAC_BITS-1:0]          out_vf,
   output logic [31:0]                   out_pixel
);
   import irr_pkg::*;

   localparam int unsigned PW = 30;
   localparam int unsigned IW = PW - FRAC_BITS;

   logic              v1_ff, v2_ff, v3_ff;
   logic              v1_in, v2_in, v3_in;
   logic              adv;
   req_beat_type      b1_ff, b2_ff, b3_ff;
   logic signed [11:0] di_ff, dj_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [PW-1:0] uq_ff, vq_ff;
   logic signed [PW-1:0] uq_in, vq_in;
   logic signed [IW-1:0] xi, yi;
   logic signed [IW:0]  wl, hl;
   logic               outside_c;

   assign adv = !v3_ff || out_ready;
   assign in_ready = adv;
   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   assign uq_in = pa_ff - pb_ff;
   assign vq_in = pc_ff + pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ff <= in_data;
         di_ff <= $signed({3'b000, in_data.coord_x}) + 12'(offset_x);
         dj_ff <= $signed({3'b000, in_data.coord_y}) + 12'(offset_y);
         b2_ff <= b1_ff;
         pa_ff <= PW'(di_ff) * PW'(cos_q);
         pb_ff <= PW'(dj_ff) * PW'(sin_q);
         pc_ff <= PW'(di_ff) * PW'(sin_q);
         pd_ff <= PW'(dj_ff) * PW'(cos_q);
         b3_ff <= b2_ff;
         uq_ff <= uq_in;
         vq_ff <= vq_in;
      end
   end

   assign xi = uq_ff[PW-1:FRAC_BITS];
   assign yi = vq_ff[PW-1:FRAC_BITS];
   assign wl = (src_width < 9'(MAX_WIDTH)) ? (IW+1)'(src_width) : (IW+1)'(MAX_WIDTH);
   assign hl = (src_height < 9'(MAX_HEIGHT)) ? (IW+1)'(src_height) : (IW+1)'(MAX_HEIGHT);
   assign outside_c = (xi < 0) || ((IW+1)'(xi) >= wl - 1) ||
                      (yi < 0) || ((IW+1)'(yi) >= hl - 1);

   assign out_valid   = v3_ff;
   assign out_kind    = b3_ff.kind;
   assign out_outside = (b3_ff.kind == KIND_PRODUCE) ? outside_c :
                        ((b3_ff.coord_x >> XW) != 0 || (b3_ff.coord_y >> YW) != 0);
   assign out_x       = (b3_ff.kind == KIND_PRODUCE) ? xi[XW-1:0] : b3_ff.coord_x[XW-1:0];
   assign out_y       = (b3_ff.kind == KIND_PRODUCE) ? yi[YW-1:0] : b3_ff.coord_y[YW-1:0];
   assign out_uf      = uq_ff[FRAC_BITS-1:0];
   assign out_vf      = vq_ff[FRAC_BITS-1:0];
   assign out_pixel   = (b3_ff.kind == KIND_PRODUCE) ? 32'h0 :
                        (((b3_ff.coord_x >> XW) == 0 && (b3_ff.coord_y >> YW) == 0) ?
                         b3_ff.pixel_in : 32'h0);
endmodule

FILE: hw/rtl/irr_back.sv
// ----------------------------------------------------------------------------
// Image rotate resampler back end
// Pulls classified beats from the queue, writes loads into four parity
// banks, reads the four neighbours and blends them over three stages.
// ----------------------------------------------------------------------------
module irr_back #(
   parameter int unsigned XW = 8,
   parameter int unsigned YW = 8,
   parameter int unsigned FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mode,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_kind,
   input  logic                 in_outside,
   input  logic                 in_load_ok,
   input  logic [XW-1:0]        in_x,
   input  logic [YW-1:0]        in_y,
   input  logic [FRAC_BITS-1:0] in_uf,
   input  logic [FRAC_BITS-1:0] in_vf,
   input  logic [31:0]          in_pixel,
   output logic                 out_valid,
   input  logic                 out_ready,
   output irr_pkg::rsp_beat_type out_data
);
   import irr_pkg::*;

   localparam int unsigned BX = (XW > 1) ? XW - 1 : 1;
   localparam int unsigned BY = (YW > 1) ? YW - 1 : 1;
   localparam int unsigned BD = 1 << (BX + BY);
   localparam int unsigned FW = FRAC_BITS + 1;
   localparam int unsigned WW = 2 * FW;
   localparam int unsigned AW = WW + 10;

   logic adv, take;
   logic r_ff, r_in, s_ff, s_in;
   logic out_ff_v;
   logic r_out_ff, r_bil_ff, s_out_ff, s_bil_ff;
   logic r_px_ff, r_py_ff;
   logic [FRAC_BITS-1:0] r_uf_ff, r_vf_ff;
   logic [WW-1:0] w_ff [4];
   logic [WW-1:0] w_in [4];
   logic [31:0] q [4];
   logic [31:0] p [4];
   logic [31:0] p_ff [4];
   logic [31:0] res_c;
   rsp_beat_type out_data_ff;
   logic [FW-1:0] ou, ov, fu, fv;

   assign adv  = !out_ff_v || out_ready;
   assign in_ready = adv;
   assign take = in_valid && adv;
   assign r_in = take && in_kind == KIND_PRODUCE;
   assign s_in = r_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [XW-1:0] xx;
      logic [YW-1:0] yy;
      logic [BX+BY-1:0] ra;
      assign xx = in_x + XW'(in_x[0] ^ 1'(b & 1));
      assign yy = in_y + YW'(in_y[0] ^ 1'(b >> 1));
      assign ra = {yy[YW-1 -: BY], xx[XW-1 -: BX]};
      irr_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
         .clock  (clock),
         .wr_en  (take && in_kind == KIND_LOAD && in_load_ok &&
                  in_x[0] == 1'(b & 1) && in_y[0] == 1'(b >> 1)),
         .wr_addr({in_y[YW-1 -: BY], in_x[XW-1 -: BX]}),
         .wr_data(in_pixel),
         .rd_en  (adv),
         .rd_addr(ra),
         .rd_data(q[b])
      );
   end

   // Bank b holds pixels with x parity b[0] and y parity b[1].
   always_comb begin
      p[0] = q[{r_py_ff, r_px_ff}];
      p[1] = q[{r_py_ff, ~r_px_ff}];
      p[2] = q[{~r_py_ff, r_px_ff}];
      p[3] = q[{~r_py_ff, ~r_px_ff}];
   end

   assign fu = {1'b0, r_uf_ff};
   assign fv = {1'b0, r_vf_ff};
   assign ou = FW'(1 << FRAC_BITS) - fu;
   assign ov = FW'(1 << FRAC_BITS) - fv;
   assign w_in[0] = WW'(ou * ov);
   assign w_in[1] = WW'(fu * ov);
   assign w_in[2] = WW'(ou * fv);
   assign w_in[3] = WW'(fu * fv);

   always_comb begin
      logic [AW-1:0] acc;
      res_c = 32'hFF00_0000;
      for (int c = 0; c < 3; c++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            acc = acc + AW'(w_ff[k]) * AW'(p_ff[k][8*c +: 8]);
         end
         res_c[8*c +: 8] = acc[2*FRAC_BITS +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= 1'b0;
         s_ff <= 1'b0;
         out_ff_v <= 1'b0;
      end else if (adv) begin
         r_ff <= r_in;
         s_ff <= s_in;
         out_ff_v <= s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_out_ff <= in_outside;
         r_bil_ff <= mode;
         r_px_ff <= in_x[0];
         r_py_ff <= in_y[0];
         r_uf_ff <= in_uf;
         r_vf_ff <= in_vf;
         s_out_ff <= r_out_ff;
         s_bil_ff <= r_bil_ff;
         w_ff <= w_in;
         p_ff <= p;
         if (s_out_ff) begin
            out_data_ff.pixel_out <= WhitePixel;
         end else if (s_bil_ff) begin
            out_data_ff.pixel_out <= res_c;
         end else begin
            out_data_ff.pixel_out <= p_ff[0];
         end
         out_data_ff.outside <= s_out_ff;
      end
   end

   assign out_valid = out_ff_v;
   assign out_data  = out_data_ff;
endmodule

FILE: sim/irr_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate resampler testbench channels
// The block's channel interfaces are compiled from the RTL folder; this file
// carries no extra channel definitions and only holds the MaxStall package.
// ----------------------------------------------------------------------------
package irr_tb_pkg;
   localparam int unsigned MaxStall = 4;
endpackage

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotate resampler testbench
// Loads source pixels, sets rotation, offsets, sizes and sampling mode, and
// checks every output pixel against a predictor of the rotate and sample path.
// Both channels idle at random; a long output stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
   import irr_pkg::*;
   import irr_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   irr_req_if req ();
   irr_rsp_if rsp ();
   irr_csr_if csr ();

   image_rotate_resampler DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   logic [31:0] frame_mem [0:65535];
   bit          frame_written [0:65535];
   logic        cfg_mode;
   int          cfg_cos, cfg_sin, cfg_off_x, cfg_off_y, cfg_width, cfg_height;
   rsp_beat_type expected_pixels [$];
   int          mismatches = 0;
   int          hold_off = 0;
   int          rsp_wait = 0;
   int          rsp_draw;
   bit          rsp_random = 1'b1;

   initial begin
      req.valid = 1'b0; req.data = '0;
      csr.valid = 1'b0; csr.data = '0;
      rsp.ready = 1'b0;
   end

   function automatic int floor_frac(longint q);
      if (q >= 0) return int'(q >>> 14);
      return int'(-((-q + 16383) >>> 14));
   endfunction

   function automatic logic [7:0] blend(int sh, longint w1, longint w2, longint w3,
                                        longint w4, logic [31:0] p1, logic [31:0] p2,
                                        logic [31:0] p3, logic [31:0] p4);
      longint acc;
      acc = w1 * ((p1 >> sh) & 8'hFF) + w2 * ((p2 >> sh) & 8'hFF)
          + w3 * ((p3 >> sh) & 8'hFF) + w4 * ((p4 >> sh) & 8'hFF);
      return acc[35:28];
   endfunction

   function automatic rsp_beat_type rotate_sample(int cx, int cy);
      rsp_beat_type r;
      longint di, dj, uq, vq, uf, vf;
      int x, y, w, h, base;
      logic [31:0] p1, p2, p3, p4;
      w = cfg_width > 256 ? 256 : cfg_width;
      h = cfg_height > 256 ? 256 : cfg_height;
      di = cx + cfg_off_x;
      dj = cy + cfg_off_y;
      uq = di * cfg_cos - dj * cfg_sin;
      vq = di * cfg_sin + dj * cfg_cos;
      x = floor_frac(uq);
      y = floor_frac(vq);
      if (x < 0 || x >= w - 1 || y < 0 || y >= h - 1) begin
         r.pixel_out = WhitePixel;
         r.outside = 1'b1;
         return r;
      end
      base = y * 256 + x;
      p1 = frame_mem[base]; p2 = frame_mem[base + 1];
      p3 = frame_mem[base + 256]; p4 = frame_mem[base + 257];
      r.outside = 1'b0;
      if (!cfg_mode) begin
         r.pixel_out = p1;
         return r;
      end
      uf = uq - longint'(x) * 16384;
      vf = vq - longint'(y) * 16384;
      r.pixel_out = {8'hFF,
         blend(16, (16384-uf)*(16384-vf), uf*(16384-vf), (16384-uf)*vf, uf*vf, p1,p2,p3,p4),
         blend(8, (16384-uf)*(16384-vf), uf*(16384-vf), (16384-uf)*vf, uf*vf, p1,p2,p3,p4),
         blend(0, (16384-uf)*(16384-vf), uf*(16384-vf), (16384-uf)*vf, uf*vf, p1,p2,p3,p4)};
      return r;
   endfunction

   // A produce beat is only sent when every sampled neighbour has been loaded.
   function automatic bit reads_written(int cx, int cy);
      longint di, dj;
      int x, y, w, h, base;
      w = cfg_width > 256 ? 256 : cfg_width;
      h = cfg_height > 256 ? 256 : cfg_height;
      di = cx + cfg_off_x;
      dj = cy + cfg_off_y;
      x = floor_frac(di * cfg_cos - dj * cfg_sin);
      y = floor_frac(di * cfg_sin + dj * cfg_cos);
      if (x < 0 || x >= w - 1 || y < 0 || y >= h - 1) return 1'b1;
      base = y * 256 + x;
      return frame_written[base] && frame_written[base + 1]
          && frame_written[base + 256] && frame_written[base + 257];
   endfunction

   task automatic write_reg(reg_index_type idx, int value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.data <= '{index: idx, data: value};
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         REG_MODE:       cfg_mode = value[0];
         REG_COS:        cfg_cos = int'($signed(value[15:0]));
         REG_SIN:        cfg_sin = int'($signed(value[15:0]));
         REG_OFFSET_X:   cfg_off_x = int'($signed(value[10:0]));
         REG_OFFSET_Y:   cfg_off_y = int'($signed(value[10:0]));
         REG_SRC_WIDTH:  cfg_width = value & 32'h1FF;
         REG_SRC_HEIGHT: cfg_height = value & 32'h1FF;
         default: ;
      endcase
   endtask

   task automatic send_beat(kind_type kind, int cx, int cy, logic [31:0] pix, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, MaxStall) : 0;
      if (kind == KIND_PRODUCE && !reads_written(cx, cy)) begin
         req.valid <= 1'b0;
         repeat (gap + 1) @(posedge clock);
         return;
      end
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{kind: kind, coord_x: cx[8:0], coord_y: cy[8:0], pixel_in: pix};
      do @(posedge clock); while (!req.ready);
      if (kind == KIND_LOAD) begin
         if (cx < 256 && cy < 256) begin
            frame_mem[cy * 256 + cx] = pix;
            frame_written[cy * 256 + cx] = 1'b1;
         end
      end else begin
         expected_pixels.push_back(rotate_sample(cx, cy));
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_patch(int x0, int y0, int n);
      for (int y = y0; y < y0 + n; y++)
         for (int x = x0; x < x0 + n; x++)
            send_beat(KIND_LOAD, x, y, $urandom, 1'b0);
   endtask

   task automatic test_directed();
      load_patch(0, 0, 4);
      load_patch(252, 252, 4);
      send_beat(KIND_LOAD, 300, 5, 32'hDEAD_BEEF, 1'b0);
      send_beat(KIND_LOAD, 5, 511, 32'h0, 1'b0);
      send_beat(KIND_LOAD, 1, 1, 32'hFFFF_FFFF, 1'b0);
      send_beat(KIND_LOAD, 2, 1, 32'h0000_0000, 1'b0);
      send_beat(KIND_PRODUCE, 0, 0, 0, 1'b0);
      send_beat(KIND_PRODUCE, 1, 1, 0, 1'b0);
      send_beat(KIND_PRODUCE, 254, 254, 0, 1'b0);
      send_beat(KIND_PRODUCE, 255, 10, 0, 1'b0);
      send_beat(KIND_PRODUCE, 511, 511, 32'hFFFF_FFFF, 1'b0);
      drain();
      write_reg(REG_MODE, 1);
      write_reg(REG_COS, 16'd8192);
      write_reg(REG_SIN, 16'd8192);
      send_beat(KIND_PRODUCE, 3, 1, 0, 1'b0);
      send_beat(KIND_PRODUCE, 1, 0, 0, 1'b0);
      drain();
      write_reg(REG_COS, 16'h8000 | 16'hC000);
      write_reg(REG_SIN, 0);
      write_reg(REG_OFFSET_X, -512);
      write_reg(REG_OFFSET_Y, -512);
      send_beat(KIND_PRODUCE, 511, 511, 0, 1'b0);
      send_beat(KIND_PRODUCE, 510, 510, 0, 1'b0);
      drain();
      write_reg(REG_OFFSET_X, 512);
      write_reg(REG_SRC_WIDTH, 1);
      write_reg(REG_SRC_HEIGHT, 0);
      send_beat(KIND_PRODUCE, 0, 0, 0, 1'b0);
      drain();
      write_reg(REG_SRC_WIDTH, 511);
      write_reg(REG_SRC_HEIGHT, 511);
      write_reg(REG_OFFSET_X, 0);
      write_reg(REG_OFFSET_Y, 0);
      write_reg(REG_COS, 16384);
      send_beat(KIND_PRODUCE, 2, 2, 0, 1'b0);
      drain();
   endtask

   task automatic test_random_settings(int beats);
      int angle;
      load_patch(0, 0, 16);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         angle = $urandom_range(0, 3);
         write_reg(REG_MODE, $urandom_range(0, 1));
         write_reg(REG_COS, angle == 0 ? 16384 : angle == 2 ? -16384 :
                   $urandom_range(0, 32768) - 16384);
         write_reg(REG_SIN, angle[0] ? ($urandom_range(0, 1) ? 16384 : -16384) :
                   $urandom_range(0, 32768) - 16384);
         write_reg(REG_OFFSET_X, $urandom_range(0, 64) - 32);
         write_reg(REG_OFFSET_Y, $urandom_range(0, 64) - 32);
         write_reg(REG_SRC_WIDTH, $urandom_range(2, 16));
         write_reg(REG_SRC_HEIGHT, $urandom_range(2, 16));
         for (int i = 0; i < beats; i++)
            if ($urandom_range(0, 2) == 0)
               send_beat(KIND_LOAD, $urandom_range(0, 15), $urandom_range(0, 15), $urandom, 1);
            else if ($urandom_range(0, 15) == 0)
               send_beat(KIND_LOAD, $urandom_range(0, 511), $urandom_range(0, 511), $urandom, 1);
            else
               send_beat(KIND_PRODUCE, $urandom_range(0, 24), $urandom_range(0, 24),
                         $urandom, 1);
         drain();
      end
   endtask

   task automatic test_backpressure();
      write_reg(REG_MODE, 1);
      write_reg(REG_COS, 16384);
      write_reg(REG_SIN, 0);
      write_reg(REG_OFFSET_X, 0);
      write_reg(REG_OFFSET_Y, 0);
      write_reg(REG_SRC_WIDTH, 4);
      write_reg(REG_SRC_HEIGHT, 4);
      hold_off = 60;
      for (int i = 0; i < 40; i++)
         send_beat(KIND_PRODUCE, $urandom_range(0, 3), $urandom_range(0, 3), 0, 1'b0);
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp.ready <= 1'b0;
      end else if (!reset && rsp.valid && rsp.ready) begin
         rsp_draw = $urandom_range(0, MaxStall);
         rsp.ready <= (rsp_draw == 0);
         rsp_wait <= (rsp_draw == 0) ? 0 : rsp_draw - 1;
      end else begin
         rsp.ready <= 1'b1;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output beat %h", rsp.data);
         end else if (expected_pixels[0] !== rsp.data) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected %h/%b actual %h/%b",
                        expected_pixels[0].pixel_out, expected_pixels[0].outside,
                        rsp.data.pixel_out, rsp.data.outside);
            void'(expected_pixels.pop_front());
         end else begin
            void'(expected_pixels.pop_front());
         end
      end
   end

   initial begin
      cfg_mode = 0; cfg_cos = 16384; cfg_sin = 0; cfg_off_x = 0; cfg_off_y = 0;
      cfg_width = 256; cfg_height = 256;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_settings(200);
      drain();
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("** image_rotate_resampler: PASSED **");
      else
         $display("** image_rotate_resampler: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** image_rotate_resampler: FAILED **");
      $finish;
   end
endmodule
